/* design/bpp_pkg.sv */
// bpp_pkg: shared types and constants for the bus packet parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bpp_pkg;

  localparam int ERROR_COUNT_BITS = 16;

  localparam logic [1:0] REG_START_BYTE  = 2'd0;
  localparam logic [1:0] REG_LEADIN_BYTE = 2'd1;
  localparam logic [1:0] REG_MAX_LENGTH  = 2'd2;

  localparam logic [7:0] START_BYTE_RESET  = 8'hAA;
  localparam logic [7:0] LEADIN_BYTE_RESET = 8'h55;
  localparam logic [4:0] MAX_LENGTH_RESET  = 5'd31;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] leadin_byte;
    logic [4:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } stage_t;

endpackage

`default_nettype wire

/* design/bpp_if.sv */
// bpp_rx_if and bpp_res_if: valid/ready channels for received bytes and parse results
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface bpp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface bpp_res_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic        frame_error;
  logic [2:0]  command;
  logic [4:0]  address;
  logic [2:0]  bank;
  logic [4:0]  length;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic [4:0]  data_index;
  logic [15:0] error_count;

  modport source (
    output valid, output frame_ok, output frame_error, output command, output address,
    output bank, output length, output data_valid, output data_byte, output data_index,
    output error_count, input ready
  );
  modport sink (
    input valid, input frame_ok, input frame_error, input command, input address,
    input bank, input length, input data_valid, input data_byte, input data_index,
    input error_count, output ready
  );
endinterface

`default_nettype wire

/* design/bpp_in_stage.sv */
// bpp_in_stage: input register for received bytes
// depends on bpp_pkg and bpp_rx_if
`timescale 1ns / 1ps
`default_nettype none

module bpp_in_stage
  import bpp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  bpp_rx_if.sink    rx,
  input  wire logic take,
  output stage_t    stg
);

  logic       valid;
  logic [7:0] data;

  assign rx.ready = !valid || take;
  assign stg.valid = valid;
  assign stg.rx_byte = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      data <= rx.rx_byte;
    end
  end

endmodule

`default_nettype wire

/* design/bpp_parser.sv */
// bpp_parser: frame state machine and result register
// depends on bpp_pkg and bpp_res_if
`timescale 1ns / 1ps
`default_nettype none

module bpp_parser
  import bpp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire stage_t stg,
  output logic        take,
  bpp_res_if.source   res
);

  typedef enum logic [2:0] {
    PH_START,
    PH_LEADIN,
    PH_HDR1,
    PH_HDR2,
    PH_DATA,
    PH_CHECK
  } phase_t;

  phase_t                      phase, phase_next;
  logic [7:0]                  running_sum, running_sum_next;
  logic [4:0]                  data_pointer, data_pointer_next;
  logic [4:0]                  frame_length, frame_length_next;
  logic [2:0]                  frame_command, frame_command_next;
  logic [4:0]                  frame_address, frame_address_next;
  logic [2:0]                  frame_bank, frame_bank_next;
  logic [ERROR_COUNT_BITS-1:0] rejects, rejects_next;
  logic                        ok_next, err_next, dv_next;
  logic [7:0]                  db_next;
  logic [4:0]                  di_next;
  logic [7:0]                  b;

  logic       valid;
  logic       frame_ok;
  logic       frame_error;
  logic       data_valid;
  logic [7:0] data_byte;
  logic [4:0] data_index;

  assign b = stg.rx_byte;
  assign take = stg.valid && (!valid || res.ready);

  always_comb begin
    phase_next         = phase;
    running_sum_next   = running_sum;
    data_pointer_next  = data_pointer;
    frame_length_next  = frame_length;
    frame_command_next = frame_command;
    frame_address_next = frame_address;
    frame_bank_next    = frame_bank;
    rejects_next       = rejects;
    ok_next            = 1'b0;
    err_next           = 1'b0;
    dv_next            = 1'b0;
    db_next            = 8'd0;
    di_next            = 5'd0;
    unique case (phase)
      PH_LEADIN: begin
        if (b == cfg.leadin_byte) begin
          phase_next       = PH_HDR1;
          running_sum_next = 8'd0;
        end else begin
          phase_next        = PH_START;
          data_pointer_next = 5'd0;
        end
      end
      PH_HDR1: begin
        frame_command_next = b[7:5];
        frame_address_next = b[4:0];
        running_sum_next   = running_sum + b;
        phase_next         = PH_HDR2;
      end
      PH_HDR2: begin
        frame_bank_next   = b[7:5];
        frame_length_next = b[4:0];
        running_sum_next  = running_sum + b;
        if (b[4:0] > cfg.max_length) begin
          rejects_next      = rejects + 1'b1;
          err_next          = 1'b1;
          phase_next        = PH_START;
          data_pointer_next = 5'd0;
        end else if (b[4:0] == 5'd0) begin
          phase_next = PH_CHECK;
        end else begin
          data_pointer_next = 5'd0;
          phase_next        = PH_DATA;
        end
      end
      PH_DATA: begin
        running_sum_next  = running_sum + b;
        dv_next           = 1'b1;
        db_next           = b;
        di_next           = data_pointer;
        data_pointer_next = data_pointer + 5'd1;
        if (data_pointer_next == frame_length) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (b == running_sum) begin
          ok_next = 1'b1;
        end else begin
          rejects_next = rejects + 1'b1;
          err_next     = 1'b1;
        end
        phase_next        = PH_START;
        data_pointer_next = 5'd0;
      end
      default: begin
        if (b == cfg.start_byte) begin
          phase_next = PH_LEADIN;
        end else begin
          phase_next = PH_START;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      running_sum   <= 8'd0;
      data_pointer  <= 5'd0;
      frame_length  <= 5'd0;
      frame_command <= 3'd0;
      frame_address <= 5'd0;
      frame_bank    <= 3'd0;
      rejects       <= '0;
      valid         <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      running_sum   <= running_sum_next;
      data_pointer  <= data_pointer_next;
      frame_length  <= frame_length_next;
      frame_command <= frame_command_next;
      frame_address <= frame_address_next;
      frame_bank    <= frame_bank_next;
      rejects       <= rejects_next;
      valid         <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      frame_ok    <= ok_next;
      frame_error <= err_next;
      data_valid  <= dv_next;
      data_byte   <= db_next;
      data_index  <= di_next;
    end
  end

  assign res.valid       = valid;
  assign res.frame_ok    = frame_ok;
  assign res.frame_error = frame_error;
  assign res.command     = frame_command;
  assign res.address     = frame_address;
  assign res.bank        = frame_bank;
  assign res.length      = frame_length;
  assign res.data_valid  = data_valid;
  assign res.data_byte   = data_byte;
  assign res.data_index  = data_index;
  assign res.error_count = 16'(rejects);

endmodule

`default_nettype wire

/* design/bus_packet_parser.sv */
// bus_packet_parser: byte-serial frame parser with additive checksum
// an accepted byte is held in the input register, and its result in the result register
// throughput: one byte per cycle while res.ready allows, set by the parser state update
// reset: synchronous, clears the parser state, error counter and both channel registers,
// and loads the configuration registers with their defaults
// depends on bpp_pkg, bpp_if, bpp_in_stage and bpp_parser
`timescale 1ns / 1ps
`default_nettype none

module bus_packet_parser
  import bpp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  bpp_rx_if.sink          rx,
  bpp_res_if.source       res
);

  cfg_t   cfg;
  stage_t stg;
  logic   take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte  <= START_BYTE_RESET;
      cfg.leadin_byte <= LEADIN_BYTE_RESET;
      cfg.max_length  <= MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_BYTE:  cfg.start_byte  <= cfg_data;
        REG_LEADIN_BYTE: cfg.leadin_byte <= cfg_data;
        REG_MAX_LENGTH:  cfg.max_length  <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  bpp_in_stage u_in_stage (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .take (take),
    .stg  (stg)
  );

  bpp_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .stg  (stg),
    .take (take),
    .res  (res)
  );

endmodule

`default_nettype wire

/* tb/sv/bus_packet_parser_tb.sv */
// bus_packet_parser_tb: self-checking testbench for the byte-serial frame parser
// predicts every result from a shadow parser and compares it on the result channel
// depends on bpp_pkg, bpp_if and bus_packet_parser
`timescale 1ns / 1ps

module bus_packet_parser_tb;
  import bpp_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTED = 50;

  typedef enum logic [2:0] {
    WAIT_START, WAIT_LEADIN, HEADER_CMD, HEADER_LEN, PAYLOAD, CHECKSUM
  } parse_phase_e;

  typedef enum int {
    GOOD_FRAME, BAD_CHECKSUM, OVERSIZE_LENGTH, BAD_LEADIN, LINE_NOISE
  } frame_kind_e;

  typedef struct packed {
    logic        frame_ok;
    logic        frame_error;
    logic [2:0]  command;
    logic [4:0]  address;
    logic [2:0]  bank;
    logic [4:0]  length;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [4:0]  data_index;
    logic [15:0] error_count;
  } parse_result_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  bpp_rx_if  rx_ch ();
  bpp_res_if res_ch ();

  bus_packet_parser dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_ch),
    .res       (res_ch)
  );

  // shadow parser state
  cfg_t         cfg_shadow;
  parse_phase_e parse_phase;
  logic [7:0]   checksum_acc;
  logic [4:0]   payload_idx;
  logic [4:0]   hdr_length;
  logic [2:0]   hdr_command;
  logic [4:0]   hdr_address;
  logic [2:0]   hdr_bank;
  logic [15:0]  reject_count;

  parse_result_t parse_results_due[$];
  int mismatches = 0;
  int results_checked = 0;
  int bytes_sent = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #5 clk = ~clk;

  function automatic parse_result_t parse_byte(logic [7:0] b);
    parse_result_t r;
    r = '0;
    case (parse_phase)
      WAIT_LEADIN: begin
        if (b == cfg_shadow.leadin_byte) begin
          parse_phase = HEADER_CMD;
          checksum_acc = 8'd0;
        end else begin
          parse_phase = WAIT_START;
          payload_idx = 5'd0;
        end
      end
      HEADER_CMD: begin
        hdr_command = b[7:5];
        hdr_address = b[4:0];
        checksum_acc += b;
        parse_phase = HEADER_LEN;
      end
      HEADER_LEN: begin
        hdr_bank = b[7:5];
        hdr_length = b[4:0];
        checksum_acc += b;
        if (hdr_length > cfg_shadow.max_length) begin
          reject_count++;
          r.frame_error = 1'b1;
          parse_phase = WAIT_START;
          payload_idx = 5'd0;
        end else if (hdr_length == 5'd0) begin
          parse_phase = CHECKSUM;
        end else begin
          payload_idx = 5'd0;
          parse_phase = PAYLOAD;
        end
      end
      PAYLOAD: begin
        checksum_acc += b;
        r.data_valid = 1'b1;
        r.data_byte = b;
        r.data_index = payload_idx;
        payload_idx++;
        if (payload_idx == hdr_length) parse_phase = CHECKSUM;
      end
      CHECKSUM: begin
        if (b == checksum_acc) begin
          r.frame_ok = 1'b1;
        end else begin
          reject_count++;
          r.frame_error = 1'b1;
        end
        parse_phase = WAIT_START;
        payload_idx = 5'd0;
      end
      default: begin
        parse_phase = (b == cfg_shadow.start_byte) ? WAIT_LEADIN : WAIT_START;
      end
    endcase
    r.command = hdr_command;
    r.address = hdr_address;
    r.bank = hdr_bank;
    r.length = hdr_length;
    r.error_count = reject_count;
    return r;
  endfunction

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    parse_results_due.push_back(parse_byte(b));
    bytes_sent++;
  endtask

  task automatic drain_results();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (parse_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] start_b, logic [7:0] leadin_b, logic [4:0] max_len);
    drain_results();
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_START_BYTE;
    cfg_data <= start_b;
    @(posedge clk);
    cfg_index <= REG_LEADIN_BYTE;
    cfg_data <= leadin_b;
    @(posedge clk);
    cfg_index <= REG_MAX_LENGTH;
    cfg_data <= {3'($urandom), max_len};
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data <= 8'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_shadow.start_byte = start_b;
    cfg_shadow.leadin_byte = leadin_b;
    cfg_shadow.max_length = max_len;
  endtask

  task automatic send_frame(frame_kind_e kind);
    logic [7:0] h1, h2, sum, b;
    int len;
    if (kind == LINE_NOISE) begin
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
      return;
    end
    send_byte(cfg_shadow.start_byte);
    if (kind == BAD_LEADIN) begin
      b = 8'($urandom);
      if (b == cfg_shadow.leadin_byte) b ^= 8'h01 << $urandom_range(7);
      send_byte(b);
      return;
    end
    send_byte(cfg_shadow.leadin_byte);
    if (kind == OVERSIZE_LENGTH && cfg_shadow.max_length != 5'd31)
      len = $urandom_range(31, cfg_shadow.max_length + 1);
    else if ($urandom_range(9) == 0)
      len = $urandom_range(cfg_shadow.max_length);
    else
      len = $urandom_range(cfg_shadow.max_length < 5'd6 ? cfg_shadow.max_length : 6);
    h1 = 8'($urandom);
    h2 = {3'($urandom), 5'(len)};
    send_byte(h1);
    send_byte(h2);
    sum = h1 + h2;
    if (len > cfg_shadow.max_length) return;
    // sender holds off mid-frame until the result channel is empty
    if ($urandom_range(49) == 0) drain_results();
    repeat (len) begin
      b = 8'($urandom);
      sum += b;
      send_byte(b);
    end
    if (kind == BAD_CHECKSUM) sum ^= 8'($urandom_range(255, 1));
    send_byte(sum);
  endtask

  function automatic frame_kind_e pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 60) return GOOD_FRAME;
    if (r < 72) return BAD_CHECKSUM;
    if (r < 82) return OVERSIZE_LENGTH;
    if (r < 92) return BAD_LEADIN;
    return LINE_NOISE;
  endfunction

  task automatic test_directed();
    logic [7:0] seq_a [15] = '{8'hAA, 8'h55, 8'hFF, 8'h00, 8'hFF,
                               8'hAA, 8'hAA, 8'h55,
                               8'hAA, 8'h55, 8'h00, 8'hE2, 8'hFF, 8'hAA, 8'h8A};
    logic [7:0] seq_b [10] = '{8'hAA, 8'h55, 8'h1F, 8'h02,
                               8'hAA, 8'h55, 8'h20, 8'h01, 8'h00, 8'h21};
    // good zero-length frame, wrong lead-in equal to start, bad checksum
    foreach (seq_a[i]) begin
      send_byte(seq_a[i]);
      if (i == 12) drain_results();
    end
    // oversize length, then a length equal to the limit
    set_config(START_BYTE_RESET, LEADIN_BYTE_RESET, 5'd1);
    foreach (seq_b[i]) send_byte(seq_b[i]);
  endtask

  task automatic test_random_frames();
    int send_pct [4] = '{0, 60, 0, 17};
    int stall_pct [4] = '{0, 0, 60, 17};
    logic [7:0] sb, lb;
    logic [4:0] ml;
    int goal;
    for (int seg = 0; seg < 8; seg++) begin
      case (seg)
        0: begin
          sb = 8'h00; lb = 8'hFF; ml = 5'd31;
        end
        1: begin
          sb = 8'hFF; lb = 8'h00; ml = 5'd0;
        end
        2: begin
          sb = START_BYTE_RESET; lb = LEADIN_BYTE_RESET; ml = MAX_LENGTH_RESET;
        end
        3: begin
          sb = 8'($urandom); lb = sb; ml = 5'($urandom_range(31));
        end
        default: begin
          sb = 8'($urandom); lb = 8'($urandom); ml = 5'($urandom_range(31));
        end
      endcase
      set_config(sb, lb, ml);
      send_idle_pct = send_pct[seg / 2];
      recv_stall_pct = stall_pct[seg / 2];
      goal = bytes_sent + 200;
      while (bytes_sent < goal) send_frame(pick_kind());
    end
  endtask

  task automatic test_reject_burst();
    set_config(START_BYTE_RESET, LEADIN_BYTE_RESET, 5'd0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) begin
      send_byte(START_BYTE_RESET);
      send_byte(LEADIN_BYTE_RESET);
      send_byte(8'($urandom));
      send_byte({3'($urandom), 5'($urandom_range(31, 1))});
    end
  endtask

  always @(posedge clk) res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    parse_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (parse_results_due.size() == 0) begin
        report("result with nothing expected");
      end else begin
        want = parse_results_due.pop_front();
        if (res_ch.frame_ok !== want.frame_ok)
          report($sformatf("#%0d frame_ok %b, want %b", results_checked,
                           res_ch.frame_ok, want.frame_ok));
        if (res_ch.frame_error !== want.frame_error)
          report($sformatf("#%0d frame_error %b, want %b", results_checked,
                           res_ch.frame_error, want.frame_error));
        if (res_ch.command !== want.command)
          report($sformatf("#%0d command %0h, want %0h", results_checked,
                           res_ch.command, want.command));
        if (res_ch.address !== want.address)
          report($sformatf("#%0d address %0h, want %0h", results_checked,
                           res_ch.address, want.address));
        if (res_ch.bank !== want.bank)
          report($sformatf("#%0d bank %0h, want %0h", results_checked,
                           res_ch.bank, want.bank));
        if (res_ch.length !== want.length)
          report($sformatf("#%0d length %0h, want %0h", results_checked,
                           res_ch.length, want.length));
        if (res_ch.data_valid !== want.data_valid)
          report($sformatf("#%0d data_valid %b, want %b", results_checked,
                           res_ch.data_valid, want.data_valid));
        if (res_ch.data_byte !== want.data_byte)
          report($sformatf("#%0d data_byte %0h, want %0h", results_checked,
                           res_ch.data_byte, want.data_byte));
        if (res_ch.data_index !== want.data_index)
          report($sformatf("#%0d data_index %0h, want %0h", results_checked,
                           res_ch.data_index, want.data_index));
        if (res_ch.error_count !== want.error_count)
          report($sformatf("#%0d error_count %0h, want %0h", results_checked,
                           res_ch.error_count, want.error_count));
      end
      results_checked++;
    end
  end

  // ends the run when no transaction has moved for too long
  always @(posedge clk) begin
    if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("** bus_packet_parser: FAILED **");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_START_BYTE;
    cfg_data = 8'h00;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'h00;
    res_ch.ready = 1'b0;
    cfg_shadow.start_byte = START_BYTE_RESET;
    cfg_shadow.leadin_byte = LEADIN_BYTE_RESET;
    cfg_shadow.max_length = MAX_LENGTH_RESET;
    parse_phase = WAIT_START;
    checksum_acc = 8'd0;
    payload_idx = 5'd0;
    hdr_length = 5'd0;
    hdr_command = 3'd0;
    hdr_address = 5'd0;
    hdr_bank = 3'd0;
    reject_count = 16'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_frames();
    test_reject_burst();
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("** bus_packet_parser: PASSED **");
    else
      $display("** bus_packet_parser: FAILED **");
    $finish;
  end

endmodule
